// ----- hw/rtl/true_peak_meter_assert.svh -----
// assertion macros shared by the true peak meter modules
// both sample on clk and stay quiet while arst_n is low
`ifndef TRUE_PEAK_METER_ASSERT_SVH
`define TRUE_PEAK_METER_ASSERT_SVH

// condition now implies consequence in the same cycle
`define TPM_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// condition now implies consequence in the next cycle
`define TPM_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ----- hw/rtl/tpm_pkg.sv -----
package tpm_pkg;

	localparam int TAPS        = 32;
	localparam int OVERSAMPLE  = 4;
	localparam int SAMPLE_BITS = 24;
	localparam int COEF_BITS   = 18;
	localparam int COEF_FRAC   = 16;

	localparam int PHASES     = OVERSAMPLE - 1;
	localparam int PHASE_W    = (PHASES > 1) ? $clog2(PHASES) : 1;
	localparam int TAP_W      = $clog2(TAPS);
	localparam int TAP_SUM_W  = TAP_W + 1;
	localparam int FILL_W     = $clog2(TAPS + 1);
	localparam int PROD_BITS  = SAMPLE_BITS + COEF_BITS;
	localparam int ACC_BITS   = PROD_BITS + $clog2(TAPS);
	localparam int PEAK_BITS  = SAMPLE_BITS + 1;
	localparam int IN_DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((SAMPLE_BITS + PEAK_BITS + 7) / 8) * 8;

	localparam logic [PEAK_BITS-1:0] PEAK_MAX = '1;

	localparam longint ONE_Q30 = 64'sd1 <<< 30;
	localparam logic [63:0] PI_Q30    = 64'd3373259426;
	localparam logic [63:0] INVPI_Q30 = 64'd341782638;

	typedef logic [PHASES-1:0][TAPS-1:0][COEF_BITS-1:0] coef_rom_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MAC,
		S_DRAIN,
		S_FINISH
	} tpm_state_t;

	typedef struct packed {
		logic               accept;
		logic               issue;
		logic               first;
		logic               last;
		logic [PHASE_W-1:0] phase;
		logic [TAP_W-1:0]   tap;
		logic               finish;
	} tpm_cmd_t;

	typedef struct packed {
		logic fill_reach;
		logic fill_full;
		logic pipe_busy;
		logic out_stall;
	} tpm_stat_t;

	// shift-subtract division for elaboration, remainder in the upper half
	function automatic logic [127:0] udivmod(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] q;
		logic [64:0] r;
		integer i;
		q = '0;
		r = '0;
		for (i = 63; i >= 0; i--) begin
			r = {r[63:0], a[i]};
			if (r >= {1'b0, b}) begin
				r = r - {1'b0, b};
				q[i] = 1'b1;
			end
		end
		return {r[63:0], q};
	endfunction

	// cos(pi*num/den) in q30, taylor series after folding into the first quadrant
	function automatic longint cos_half(input longint num, input longint den);
		longint n;
		longint sum;
		logic [63:0] th;
		logic [63:0] t2;
		logic [63:0] term;
		logic [127:0] dm;
		logic neg;
		integer k;
		neg = 1'b0;
		n = (num < 0) ? -num : num;
		dm = udivmod(64'(n), 64'(2 * den));
		n = $signed(dm[127:64]);
		if (n > den)
			n = 2 * den - n;
		if (2 * n > den) begin
			n = den - n;
			neg = 1'b1;
		end
		dm = udivmod(PI_Q30 * 64'(n), 64'(den));
		th = dm[63:0];
		t2 = (th * th) >> 30;
		term = 64'(ONE_Q30);
		sum = ONE_Q30;
		for (k = 1; k <= 12; k++) begin
			dm = udivmod((term * t2) >> 30, 64'((2 * k - 1) * (2 * k)));
			term = dm[63:0];
			if (k[0])
				sum = sum - $signed(term);
			else
				sum = sum + $signed(term);
		end
		return neg ? -sum : sum;
	endfunction

	// hann-windowed sinc per phase, normalised to unit sum, q2.16
	function automatic coef_rom_t build_rom();
		coef_rom_t rom;
		longint raw [TAPS];
		longint sum;
		longint sinpf;
		longint m;
		longint w;
		longint c;
		longint cmax;
		longint cmin;
		logic [63:0] sinv;
		logic [63:0] sinc_mag;
		logic [63:0] mag;
		logic [63:0] a;
		logic [127:0] dm;
		logic negc;
		integer p;
		integer t;
		rom = '0;
		cmax = (64'sd1 <<< (COEF_BITS - 1)) - 1;
		cmin = -(64'sd1 <<< (COEF_BITS - 1));
		for (p = 1; p < OVERSAMPLE; p++) begin
			sum = 0;
			sinpf = cos_half(longint'(2 * p - OVERSAMPLE), longint'(2 * OVERSAMPLE));
			if (sinpf < 0)
				sinpf = 0;
			sinv = (64'(sinpf) * INVPI_Q30) >> 30;
			for (t = 0; t < TAPS; t++) begin
				m = longint'(t * OVERSAMPLE - p);
				w = ONE_Q30 + cos_half(m, longint'(OVERSAMPLE * TAPS));
				if (w < 0)
					w = 0;
				w = w >>> 1;
				if (m == 0) begin
					sinc_mag = 64'(ONE_Q30);
					negc = 1'b0;
				end else begin
					a = 64'((m < 0) ? -m : m);
					dm = udivmod(sinv * 64'(OVERSAMPLE), a);
					sinc_mag = dm[63:0];
					negc = (t != 0) && !t[0];
				end
				mag = (sinc_mag * 64'(w)) >> 30;
				raw[t] = negc ? -$signed(mag) : $signed(mag);
				sum = sum + raw[t];
			end
			if (sum <= 0)
				sum = ONE_Q30;
			for (t = 0; t < TAPS; t++) begin
				a = 64'((raw[t] < 0) ? -raw[t] : raw[t]);
				dm = udivmod((a << COEF_FRAC) + (64'(sum) >> 1), 64'(sum));
				c = $signed(dm[63:0]);
				if (raw[t] < 0)
					c = -c;
				if (c > cmax)
					c = cmax;
				if (c < cmin)
					c = cmin;
				rom[p-1][t] = COEF_BITS'(c);
			end
		end
		return rom;
	endfunction

	localparam coef_rom_t COEF_ROM = build_rom();

endpackage

// ----- hw/rtl/true_peak_meter.sv -----
// True peak meter with 4x polyphase oversampling. Each input item carries one signed Q1.23
// sample (tdata), the end-of-block mark (tlast) and a restart flag (tuser) that clears the
// history, fill count and running maxima before the sample is taken. Once 32 samples sit in
// the history ring, three interpolated values between samples come from a 32-tap filter; the
// true peak of a sample is the largest of its own magnitude and those three. One result item
// (block sample peak and block true peak) leaves on the sample that ends a block. Until the
// ring is full an item skips the filter; after that the single multiply-accumulate unit
// works through 3 phases of 32 taps reading one history entry a cycle, then the pipeline
// drains; no new item is taken meanwhile. A finished result waits in an output register
// while the next item is taken; the history ring needs no clearing pass after reset.
module true_peak_meter
	import tpm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // sample_value
	input  logic                  s_axis_tlast,
	input  logic                  s_axis_tuser,  // restart
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata   // sample_peak, true_peak, zero pad
);

	tpm_cmd_t               cmd;
	tpm_stat_t              stat;
	logic [SAMPLE_BITS-1:0] out_spk;
	logic [PEAK_BITS-1:0]   out_tp;

	tpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tpm_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_sample       ($signed(s_axis_tdata[SAMPLE_BITS-1:0])),
		.in_block_end    (s_axis_tlast),
		.in_restart      (s_axis_tuser),
		.cmd             (cmd),
		.stat            (stat),
		.out_ready       (m_axis_tready),
		.out_valid       (m_axis_tvalid),
		.out_sample_peak (out_spk),
		.out_true_peak   (out_tp)
	);

	assign m_axis_tdata = OUT_DATA_W'({out_tp, out_spk});

endmodule

// ----- hw/rtl/tpm_ram.sv -----
module tpm_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/tpm_ctrl.sv -----
`include "true_peak_meter_assert.svh"

module tpm_ctrl
	import tpm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  tpm_stat_t stat,
	output tpm_cmd_t  cmd
);

	tpm_state_t         state_q;
	tpm_state_t         state_d;
	logic [TAP_W-1:0]   tap_q;
	logic [PHASE_W-1:0] phase_q;
	logic               tap_last;
	logic               phase_last;

	assign tap_last   = (tap_q == TAP_W'(TAPS - 1));
	assign phase_last = (phase_q == PHASE_W'(PHASES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tap_q   <= '0;
			phase_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.accept) begin
				tap_q   <= '0;
				phase_q <= '0;
			end else if (cmd.issue) begin
				if (tap_last) begin
					tap_q   <= '0;
					phase_q <= phase_last ? '0 : phase_q + PHASE_W'(1);
				end else begin
					tap_q <= tap_q + TAP_W'(1);
				end
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd        = '0;
		cmd.phase  = phase_q;
		cmd.tap    = tap_q;
		cmd.first  = (tap_q == '0);
		cmd.last   = tap_last;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = stat.fill_reach ? S_MAC : S_FINISH;
				end
			end
			S_MAC: begin
				cmd.issue = 1'b1;
				if (tap_last && phase_last)
					state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (!stat.pipe_busy)
					state_d = S_FINISH;
			end
			S_FINISH: begin
				// a block result waits here until the output register is free
				if (!stat.out_stall) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	`TPM_ASSERT_IMP(a_finish_drained, state_q == S_FINISH, !stat.pipe_busy, "filter busy")
	`TPM_ASSERT_IMP(a_mac_ring_full, state_q == S_MAC, stat.fill_full, "partial history")

endmodule

// ----- hw/rtl/tpm_dp.sv -----
`include "true_peak_meter_assert.svh"

module tpm_dp
	import tpm_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic signed [SAMPLE_BITS-1:0] in_sample,
	input  logic                          in_block_end,
	input  logic                          in_restart,
	input  tpm_cmd_t                      cmd,
	output tpm_stat_t                     stat,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [SAMPLE_BITS-1:0]        out_sample_peak,
	output logic [PEAK_BITS-1:0]          out_true_peak
);

	// block state
	logic [TAP_W-1:0]       slot_q;
	logic [FILL_W-1:0]      fill_q;
	logic [SAMPLE_BITS-1:0] spk_q;
	logic [PEAK_BITS-1:0]   btp_q;
	logic [PEAK_BITS-1:0]   tp_q;
	logic [TAP_W-1:0]       base_q;
	logic                   blk_end_q;

	// accept-side logic
	logic [TAP_W-1:0]       wr_slot;
	logic [FILL_W-1:0]      fill_base;
	logic [FILL_W-1:0]      fill_next;
	logic [SAMPLE_BITS-1:0] mag;
	logic [SAMPLE_BITS-1:0] spk_base;
	logic [PEAK_BITS-1:0]   tp_blk;

	// filter pipeline
	logic [TAP_SUM_W-1:0]          rd_sum;
	logic [TAP_W-1:0]              raddr;
	logic [SAMPLE_BITS-1:0]        rdata;
	logic signed [COEF_BITS-1:0]   coef_s1;
	logic                          valid_s1;
	logic                          first_s1;
	logic                          last_s1;
	logic signed [PROD_BITS-1:0]   prod_s2;
	logic                          valid_s2;
	logic                          first_s2;
	logic                          last_s2;
	logic signed [ACC_BITS-1:0]    acc_q;
	logic                          last_s3;
	logic [ACC_BITS-1:0]           abs_acc;
	logic [ACC_BITS-1:0]           rnd;
	logic [PEAK_BITS-1:0]          vpk;
	logic [PEAK_BITS-1:0]          vpk_s4;
	logic                          vvalid_s4;

	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] out_spk_q;
	logic [PEAK_BITS-1:0]   out_tp_q;

	// restart clears everything before the item is taken
	assign wr_slot   = in_restart ? '0 : slot_q;
	assign fill_base = in_restart ? '0 : fill_q;
	assign fill_next = (fill_base == FILL_W'(TAPS)) ? fill_base : fill_base + FILL_W'(1);
	assign spk_base  = in_restart ? '0 : spk_q;
	assign mag       = in_sample[SAMPLE_BITS-1] ? (~in_sample + SAMPLE_BITS'(1)) : in_sample;
	assign tp_blk    = (tp_q > btp_q) ? tp_q : btp_q;

	assign stat.fill_reach = (fill_next == FILL_W'(TAPS));
	assign stat.fill_full  = (fill_q == FILL_W'(TAPS));
	assign stat.pipe_busy  = valid_s1 | valid_s2 | last_s3 | vvalid_s4;
	assign stat.out_stall  = blk_end_q & out_valid_q & ~out_ready;

	// tap t reads the sample t steps older than the newest one
	assign rd_sum = (base_q >= cmd.tap) ?
		({1'b0, base_q} - {1'b0, cmd.tap}) :
		({1'b0, base_q} + TAP_SUM_W'(TAPS) - {1'b0, cmd.tap});
	assign raddr = rd_sum[TAP_W-1:0];

	tpm_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(TAPS)
	) u_ring (
		.clk   (clk),
		.we    (cmd.accept),
		.waddr (wr_slot),
		.wdata (in_sample),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign abs_acc = acc_q[ACC_BITS-1] ? (~acc_q + ACC_BITS'(1)) : acc_q;
	assign rnd     = (abs_acc + (ACC_BITS'(1) << (COEF_FRAC - 1))) >> COEF_FRAC;
	assign vpk     = (rnd > ACC_BITS'(PEAK_MAX)) ? PEAK_MAX : rnd[PEAK_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= '0;
			fill_q      <= '0;
			spk_q       <= '0;
			btp_q       <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			last_s3     <= 1'b0;
			vvalid_s4   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1  <= cmd.issue;
			valid_s2  <= valid_s1;
			last_s3   <= valid_s2 & last_s2;
			vvalid_s4 <= last_s3;
			if (cmd.finish && blk_end_q)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (cmd.accept) begin
				slot_q <= (wr_slot == TAP_W'(TAPS - 1)) ? '0 : wr_slot + TAP_W'(1);
				fill_q <= fill_next;
				spk_q  <= (mag > spk_base) ? mag : spk_base;
				if (in_restart)
					btp_q <= '0;
			end
			if (cmd.finish) begin
				if (blk_end_q) begin
					spk_q <= '0;
					btp_q <= '0;
				end else begin
					btp_q <= tp_blk;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			base_q    <= wr_slot;
			blk_end_q <= in_block_end;
		end
		coef_s1  <= $signed(COEF_ROM[cmd.phase][cmd.tap]);
		first_s1 <= cmd.first;
		last_s1  <= cmd.last;
		prod_s2  <= $signed(rdata) * coef_s1;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		if (valid_s2)
			acc_q <= first_s2 ? ACC_BITS'(prod_s2) : acc_q + ACC_BITS'(prod_s2);
		vpk_s4 <= vpk;
		// the item's own magnitude seeds its true peak
		if (cmd.accept)
			tp_q <= {1'b0, mag};
		else if (vvalid_s4 && (vpk_s4 > tp_q))
			tp_q <= vpk_s4;
		if (cmd.finish && blk_end_q) begin
			out_spk_q <= spk_q;
			out_tp_q  <= tp_blk;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_sample_peak = out_spk_q;
	assign out_true_peak   = out_tp_q;

	`TPM_ASSERT_IMP(a_tp_covers_spk, out_valid_q, out_tp_q >= {1'b0, out_spk_q}, "tp under spk")
	`TPM_ASSERT_IMP(a_out_src, $rose(out_valid_q), $past(cmd.finish && blk_end_q), "stray result")
	`TPM_ASSERT_NEXT(a_fill_tracks, cmd.accept && stat.fill_reach, stat.fill_full, "fill lost")

endmodule

// ----- tb/sv/true_peak_meter_tb.sv -----
`timescale 1ns / 100ps

module true_peak_meter_tb
	import tpm_pkg::*;
();

	localparam longint          Q30_ONE    = 64'sd1 <<< 30;
	localparam longint unsigned Q30_PI     = 64'd3373259426;
	localparam longint unsigned Q30_INV_PI = 64'd341782638;
	localparam longint          TP_LIMIT   = (64'sd1 <<< PEAK_BITS) - 1;

	localparam logic signed [SAMPLE_BITS-1:0] FULL_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] FULL_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	typedef enum int {
		MIX_RANDOM,
		MIX_FULL_SCALE,
		MIX_QUIET,
		MIX_EXTREME
	} sample_mix_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample_peak;
		logic [PEAK_BITS-1:0]   true_peak;
	} block_peaks_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;   // sample_value
	logic                  s_axis_tlast;   // block_end
	logic                  s_axis_tuser;   // restart
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;   // sample_peak, true_peak, zero pad

	// filter taps per phase and the meter state as the block should hold it
	longint coef_tab [PHASES][TAPS];
	longint ring_hist [TAPS];
	int     ring_slot;
	int     ring_fill;
	longint run_sample_peak;
	longint run_true_peak;

	block_peaks_t expected_peaks [$];

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	bit hold_req    = 1'b0;
	int hold_len    = 0;

	int n_samples   = 0;
	int n_full      = 0;
	int n_restarts  = 0;
	int n_checked   = 0;
	int n_errors    = 0;
	longint top_true_peak = 0;

	true_peak_meter u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// cos(pi*num/den) in q30, folded into the first quadrant, taylor series
	function automatic longint cos_q30(input longint num, input longint den);
		longint unsigned th;
		longint unsigned t2;
		longint unsigned term;
		longint sum;
		bit neg;
		neg = 1'b0;
		if (den <= 0)
			return Q30_ONE;
		if (num < 0)
			num = -num;
		num = num % (2 * den);
		if (num > den)
			num = 2 * den - num;
		if (2 * num > den) begin
			num = den - num;
			neg = 1'b1;
		end
		th = Q30_PI * longint'(num) / longint'(den);
		t2 = (th * th) >> 30;
		term = Q30_ONE;
		sum = Q30_ONE;
		for (int k = 1; k <= 12; k++) begin
			term = ((term * t2) >> 30) / longint'((2 * k - 1) * (2 * k));
			if (k % 2 == 1)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		return neg ? -sum : sum;
	endfunction

	// windowed sinc per phase, scaled to unit sum, rounded to q2.16
	function automatic void make_coef_table();
		longint raw [TAPS];
		longint sum;
		longint sinpf;
		longint m;
		longint w;
		longint c;
		longint cmax;
		longint cmin;
		longint unsigned sinc_mag;
		longint unsigned mag;
		longint unsigned a;
		bit negc;
		cmax = (64'sd1 <<< (COEF_BITS - 1)) - 1;
		cmin = -(64'sd1 <<< (COEF_BITS - 1));
		for (int p = 1; p < OVERSAMPLE; p++) begin
			sum = 0;
			sinpf = cos_q30(longint'(2 * p - OVERSAMPLE), longint'(2 * OVERSAMPLE));
			if (sinpf < 0)
				sinpf = 0;
			for (int t = 0; t < TAPS; t++) begin
				m = longint'(t) * OVERSAMPLE - p;
				w = Q30_ONE + cos_q30(m, longint'(OVERSAMPLE) * TAPS);
				if (w < 0)
					w = 0;
				w = w / 2;
				if (m == 0) begin
					sinc_mag = Q30_ONE;
					negc = 1'b0;
				end else begin
					a = (m < 0) ? -m : m;
					sinc_mag = ((longint'(sinpf) * Q30_INV_PI) >> 30) * OVERSAMPLE / a;
					negc = (t != 0) && (t % 2 == 0);
				end
				mag = (sinc_mag * longint'(w)) >> 30;
				raw[t] = negc ? -longint'(mag) : longint'(mag);
				sum = sum + raw[t];
			end
			if (sum <= 0)
				sum = Q30_ONE;
			for (int t = 0; t < TAPS; t++) begin
				a = (raw[t] < 0) ? -raw[t] : raw[t];
				c = longint'(((a << COEF_FRAC) + longint'(sum) / 2) / longint'(sum));
				if (raw[t] < 0)
					c = -c;
				if (c > cmax)
					c = cmax;
				if (c < cmin)
					c = cmin;
				coef_tab[p-1][t] = c;
			end
		end
	endfunction

	function automatic void clear_meter();
		foreach (ring_hist[i])
			ring_hist[i] = 0;
		ring_slot = 0;
		ring_fill = 0;
		run_sample_peak = 0;
		run_true_peak = 0;
	endfunction

	// one accepted item: update history and maxima, queue the block peaks on block end
	function automatic void meter_sample(input logic signed [SAMPLE_BITS-1:0] smp,
		input bit last, input bit rst);
		longint s;
		longint acc;
		longint mag;
		longint tp;
		longint v;
		block_peaks_t r;
		if (rst) begin
			clear_meter();
			n_restarts++;
		end
		s = longint'(smp);
		ring_hist[ring_slot] = s;
		ring_slot = (ring_slot + 1) % TAPS;
		if (ring_fill < TAPS)
			ring_fill++;
		mag = (s < 0) ? -s : s;
		tp = mag;
		if (ring_fill >= TAPS) begin
			n_full++;
			for (int p = 0; p < PHASES; p++) begin
				acc = 0;
				for (int t = 0; t < TAPS; t++)
					acc += ring_hist[(ring_slot + TAPS - 1 - t) % TAPS] * coef_tab[p][t];
				v = (acc < 0) ? -acc : acc;
				v = (v + (64'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
				if (v > TP_LIMIT)
					v = TP_LIMIT;
				if (v > tp)
					tp = v;
			end
		end
		if (mag > run_sample_peak)
			run_sample_peak = mag;
		if (tp > run_true_peak)
			run_true_peak = tp;
		if (tp > top_true_peak)
			top_true_peak = tp;
		n_samples++;
		if (last) begin
			r.sample_peak = run_sample_peak[SAMPLE_BITS-1:0];
			r.true_peak = run_true_peak[PEAK_BITS-1:0];
			expected_peaks = {expected_peaks, r};
			run_sample_peak = 0;
			run_true_peak = 0;
		end
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input sample_mix_t mix,
		input int idx, input int period);
		case (mix)
			MIX_RANDOM: begin
				return SAMPLE_BITS'($urandom());
			end
			// square-ish full-scale runs give overs between samples
			MIX_FULL_SCALE: begin
				return ((idx / period) % 2 == 1) ? FULL_NEG : FULL_POS;
			end
			MIX_QUIET: begin
				return SAMPLE_BITS'(int'($urandom_range(0, 511)) - 256);
			end
			default: begin
				case ($urandom_range(0, 4))
					0: return FULL_POS;
					1: return FULL_NEG;
					2: return '0;
					3: return SAMPLE_BITS'(-1);
					default: return SAMPLE_BITS'(1);
				endcase
			end
		endcase
	endfunction

	function automatic int idle_rate();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 10;
			default: return 35;
		endcase
	endfunction

	task automatic note_error(input string what, input longint want, input longint got);
		n_errors++;
		if (n_errors <= 10)
			$display("error: %s expected %0d, got %0d (result %0d)", what, want, got,
				n_checked);
	endtask

	// inputs move on the falling edge, the handshake is seen on the rising edge
	task automatic send_item(input logic signed [SAMPLE_BITS-1:0] smp, input bit last,
		input bit rst);
		int gap;
		@(negedge clk);
		gap = ($urandom_range(0, 99) < tx_idle_pct) ? $urandom_range(1, 7) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= smp;
		s_axis_tlast <= last;
		s_axis_tuser <= rst;
		do
			@(posedge clk);
		while (!s_axis_tready);
		meter_sample(smp, last, rst);
	endtask

	task automatic hold_sender();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic send_block(input int len, input bit may_restart);
		sample_mix_t mix;
		int pick;
		int period;
		bit rst_first;
		bit rst;
		pick = $urandom_range(0, 99);
		mix = (pick < 35) ? MIX_RANDOM : (pick < 65) ? MIX_FULL_SCALE :
			(pick < 80) ? MIX_QUIET : MIX_EXTREME;
		period = $urandom_range(1, 4);
		rst_first = may_restart && ($urandom_range(0, 29) == 0);
		for (int i = 0; i < len; i++) begin
			rst = (i == 0 && rst_first) || (may_restart && $urandom_range(0, 199) == 0);
			send_item(pick_sample(mix, i, period), i == len - 1, rst);
		end
	endtask

	// short blocks before the history fills: field extremes and restart cases
	task automatic test_directed_extremes();
		send_item(FULL_POS, 1'b1, 1'b1);    // restart together with block end
		send_item(FULL_NEG, 1'b1, 1'b0);
		send_item('0, 1'b1, 1'b0);
		send_item(SAMPLE_BITS'(-1), 1'b0, 1'b0);
		send_item(SAMPLE_BITS'(1), 1'b1, 1'b0);
		send_item(24'sh123456, 1'b0, 1'b0);
		send_item(SAMPLE_BITS'(-3), 1'b1, 1'b1);   // earlier sample must be forgotten
		send_item(FULL_POS, 1'b0, 1'b0);
		send_item(FULL_NEG, 1'b0, 1'b0);
		send_item(24'sh555555, 1'b0, 1'b0);
		send_item(24'shaaaaaa, 1'b1, 1'b0);
		send_item(FULL_NEG, 1'b0, 1'b0);
		send_item(SAMPLE_BITS'(100), 1'b0, 1'b1);  // restart mid block
		send_item(SAMPLE_BITS'(-50), 1'b1, 1'b0);
	endtask

	task automatic test_random_blocks(input int count);
		int sent;
		int pick;
		int len;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 3) == 0) begin
				tx_idle_pct = idle_rate();
				rx_idle_pct = idle_rate();
			end
			pick = $urandom_range(0, 9);
			len = (pick < 7) ? $urandom_range(1, 40) :
				(pick < 9) ? $urandom_range(41, 120) : $urandom_range(1, 3);
			send_block(len, 1'b1);
			sent += len;
		end
	endtask

	// receiver stops for a long stretch while one-item blocks keep coming
	task automatic test_output_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_sender();
		hold_len = 1000;
		hold_req = 1'b1;
		for (int i = 0; i < 8; i++)
			send_item(pick_sample(MIX_RANDOM, i, 1), 1'b1, 1'b0);
	endtask

	task automatic test_steady_stream(input int count);
		int sent;
		int len;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		sent = 0;
		while (sent < count) begin
			len = $urandom_range(1, 40);
			send_block(len, 1'b1);
			sent += len;
		end
	endtask

	// result side ready, with random stall bursts and the long hold on request
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = hold_len;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if ($urandom_range(0, 99) < rx_idle_pct) begin
				stall_left = $urandom_range(1, 7) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		block_peaks_t got;
		block_peaks_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.sample_peak = m_axis_tdata[SAMPLE_BITS-1:0];
			got.true_peak = m_axis_tdata[SAMPLE_BITS +: PEAK_BITS];
			if (expected_peaks.size() == 0) begin
				note_error("no result pending, sample_peak", -1, longint'(got.sample_peak));
			end else begin
				want = expected_peaks[0];
				expected_peaks.delete(0);
				if (got.sample_peak !== want.sample_peak)
					note_error("sample_peak", longint'(want.sample_peak),
						longint'(got.sample_peak));
				if (got.true_peak !== want.true_peak)
					note_error("true_peak", longint'(want.true_peak),
						longint'(got.true_peak));
			end
			n_checked++;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		s_axis_tuser = 1'b0;
		make_coef_table();
		clear_meter();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_extremes();
		test_random_blocks(1000);
		test_output_backpressure();
		test_steady_stream(150);

		hold_sender();
		while (expected_peaks.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
		n_errors += expected_peaks.size();

		$display("%0d samples sent, %0d with a full history, %0d restarts", n_samples, n_full,
			n_restarts);
		$display("%0d block results checked, highest true peak %0d, %0d errors", n_checked,
			top_true_peak, n_errors);
		if (n_errors == 0)
			$display("true_peak_meter: match");
		else
			$display("true_peak_meter: mismatch");
		$finish;
	end

	initial begin
		#15_000_000;
		$display("timeout with %0d block results outstanding", expected_peaks.size());
		$display("true_peak_meter: mismatch");
		$finish;
	end

endmodule
